// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, idle during reset
`define DIVU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("divider check failed");

// next-cycle implication, sampled on clk, idle during reset
`define DIVU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("divider check failed");

`endif

// ----- rtl/divu_pkg.sv -----
package divu_pkg;

    localparam int DEFAULT_WIDTH = 64;

    typedef struct packed {
        logic load;
        logic step;
        logic take;
    } cell_ctrl_t;

endpackage

// ----- rtl/divu_cell.sv -----
module divu_cell (
    input  logic                clk,
    input  divu_pkg::cell_ctrl_t ctrl,
    input  logic                dividend_bit,
    input  logic                divisor_bit,
    input  logic                rem_in,
    input  logic                quo_in,
    input  logic                borrow_in,
    output logic                borrow_out,
    output logic                rem,
    output logic                quo
);

    logic rem_reg;
    logic rem_next;
    logic quo_reg;
    logic quo_next;
    logic dsor_reg;
    logic dsor_next;
    logic diff;

    // one bit of the trial subtraction of the shifted remainder
    assign diff       = rem_in ^ dsor_reg ^ borrow_in;
    assign borrow_out = (~rem_in & dsor_reg) | (~rem_in & borrow_in) | (dsor_reg & borrow_in);

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsor_next = dsor_reg;
        if (ctrl.load)
        begin
            rem_next  = 1'b0;
            quo_next  = dividend_bit;
            dsor_next = divisor_bit;
        end
        else if (ctrl.step)
        begin
            rem_next = ctrl.take ? diff : rem_in;
            quo_next = quo_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsor_reg <= dsor_next;
    end

    assign rem = rem_reg;
    assign quo = quo_reg;

endmodule

// ----- rtl/unsigned_restoring_divider.sv -----
// channel  dir  fields (low bit up)                     accepted when
// s_*      in   tdata: dividend, divisor                s_tvalid && s_tready
// m_*      out  tdata: quotient, remainder; tuser: dbz  m_tvalid && m_tready
//
// one request steps through the cell row, one quotient bit a cycle, and its result then moves
// into the output register once that register is empty or being read
// the trial subtraction ripples its borrow across the whole row each cycle
// a new request is taken the cycle after the row hands its result on
// a stalled result waits in the output register while the next request runs
// rst_n clears the control state only; the cell row holds no reset
module unsigned_restoring_divider #(
    parameter int WIDTH = divu_pkg::DEFAULT_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((2 * WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // dividend, divisor
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((2 * WIDTH + 7) / 8) * 8 - 1:0] m_tdata,  // quotient, remainder
    output logic                                m_tuser    // div_by_zero
);

    localparam int BUS_W = ((2 * WIDTH + 7) / 8) * 8;
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              dbz_reg;
    logic              dbz_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [WIDTH-1:0]  quo_out_reg;
    logic [WIDTH-1:0]  quo_out_next;
    logic [WIDTH-1:0]  rem_out_reg;
    logic [WIDTH-1:0]  rem_out_next;
    logic              dbz_out_reg;
    logic              dbz_out_next;

    logic [WIDTH-1:0]  dividend;
    logic [WIDTH-1:0]  divisor;
    logic [WIDTH-1:0]  rem_bits;
    logic [WIDTH-1:0]  quo_bits;
    logic [WIDTH:0]    borrow;
    logic              accept;
    logic              handoff;
    divu_pkg::cell_ctrl_t ctrl;

    assign dividend = s_tdata[WIDTH-1:0];
    assign divisor  = s_tdata[2*WIDTH-1:WIDTH];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign handoff  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign borrow[0] = 1'b0;
    assign ctrl.load = accept;
    assign ctrl.step = (state_reg == ST_RUN);
    // subtract when the bit shifted out was set or the trial did not borrow
    assign ctrl.take = rem_bits[WIDTH-1] | ~borrow[WIDTH];

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        logic rem_in;
        logic quo_in;

        if (i == 0)
        begin : g_first
            assign rem_in = quo_bits[WIDTH-1];
            assign quo_in = ctrl.take;
        end
        else
        begin : g_rest
            assign rem_in = rem_bits[i-1];
            assign quo_in = quo_bits[i-1];
        end

        divu_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .dividend_bit (dividend[i]),
            .divisor_bit  (divisor[i]),
            .rem_in       (rem_in),
            .quo_in       (quo_in),
            .borrow_in    (borrow[i]),
            .borrow_out   (borrow[i+1]),
            .rem          (rem_bits[i]),
            .quo          (quo_bits[i])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        dbz_next      = dbz_reg;
        m_tvalid_next = m_tvalid_reg;
        quo_out_next  = quo_out_reg;
        rem_out_next  = rem_out_reg;
        dbz_out_next  = dbz_out_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                    dbz_next   = (divisor == '0);
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (handoff)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    quo_out_next  = dbz_reg ? '0 : quo_bits;
                    rem_out_next  = dbz_reg ? '0 : rem_bits;
                    dbz_out_next  = dbz_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            dbz_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            dbz_reg      <= dbz_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_out_reg <= quo_out_next;
        rem_out_reg <= rem_out_next;
        dbz_out_reg <= dbz_out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = BUS_W'({rem_out_reg, quo_out_reg});
    assign m_tuser  = dbz_out_reg;

endmodule

// ----- rtl/divu_checker.sv -----
`include "assert_macros.svh"

module divu_checker #(
    parameter int WIDTH = divu_pkg::DEFAULT_WIDTH
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [((2 * WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((2 * WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    input logic                                m_tuser
);

    // divide by zero gives zero quotient and remainder
    `DIVU_ASSERT_NOW(a_dbz_zero, m_tvalid && m_tuser, m_tdata == '0)

    // a stalled result holds
    `DIVU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))

    // only one request in the cell row at a time
    `DIVU_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)

    // a fresh request cannot produce a result in the next cycle
    `DIVU_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready, !$rose(m_tvalid))

    // an accepted request carries known operands
    `DIVU_ASSERT_NOW(a_req_known, s_tvalid && s_tready, !$isunknown(s_tdata))

endmodule

bind unsigned_restoring_divider divu_checker #(
    .WIDTH (WIDTH)
) u_divu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- verif/unsigned_restoring_divider_tb.sv -----
module unsigned_restoring_divider_tb;

    localparam int W   = divu_pkg::DEFAULT_WIDTH;
    localparam int TDW = ((2 * W + 7) / 8) * 8;

    typedef struct packed {
        logic [W-1:0] quotient;
        logic [W-1:0] remainder;
        logic         div_by_zero;
    } div_result_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [TDW-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [TDW-1:0] m_tdata;
    logic           m_tuser;

    div_result_t    pending_results[$];
    int             mismatch_count = 0;
    bit             sender_idle_on = 1'b1;
    bit             sink_idle_on = 1'b1;

    unsigned_restoring_divider #(.WIDTH(W)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    function automatic div_result_t divide_expected(input logic [W-1:0] dividend,
                                                    input logic [W-1:0] divisor);
        div_result_t r;
        if (divisor == '0)
        begin
            r.quotient    = '0;
            r.remainder   = '0;
            r.div_by_zero = 1'b1;
        end
        else
        begin
            r.quotient    = dividend / divisor;
            r.remainder   = dividend % divisor;
            r.div_by_zero = 1'b0;
        end
        return r;
    endfunction

    // spread of magnitudes so both short and long quotients occur
    function automatic logic [W-1:0] random_operand();
        logic [63:0]  raw;
        logic [W-1:0] v;
        raw = {$urandom, $urandom};
        v   = raw[W-1:0];
        case ($urandom_range(0, 5)) inside
            0: return v;
            1, 2: return v >> (W - $urandom_range(1, W));
            3: return W'($urandom_range(0, 3));
            4: return ~W'($urandom_range(0, 3));
            default: return W'(1) << $urandom_range(0, W - 1);
        endcase
    endfunction

    function automatic logic [W-1:0] random_divisor();
        if ($urandom_range(0, 31) == 0)
            return '0;
        return random_operand();
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        mismatch_count++;
    endtask

    // entered and left at a falling edge
    task automatic send_request(input logic [W-1:0] dividend, input logic [W-1:0] divisor);
        while (sender_idle_on && $urandom_range(0, 99) < 27)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = TDW'({divisor, dividend});
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(divide_expected(dividend, divisor));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= !(sink_idle_on && $urandom_range(0, 99) < 27);

    always @(posedge clk)
    begin
        div_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("request result with nothing pending", m_tdata[W-1:0], '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[W-1:0] !== want.quotient)
                    report_mismatch("quotient", m_tdata[W-1:0], want.quotient);
                if (m_tdata[2*W-1:W] !== want.remainder)
                    report_mismatch("remainder", m_tdata[2*W-1:W], want.remainder);
                if (m_tuser !== want.div_by_zero)
                    report_mismatch("div_by_zero", W'(m_tuser), W'(want.div_by_zero));
            end
        end
    end

    task automatic test_corner_operands();
        logic [W-1:0] ones;
        logic [W-1:0] top;
        ones = '1;
        top  = W'(1) << (W - 1);
        send_request('0, W'(1));
        send_request('0, '0);
        send_request(ones, '0);
        send_request(W'(12345), '0);
        send_request(ones, W'(1));
        send_request(ones, ones);
        send_request(W'(1), ones);
        send_request(ones - W'(1), ones);
        send_request(ones, W'(2));
        send_request(ones, top);
        send_request(top, top - W'(1));
        send_request(top, W'(3));
        send_request(top - W'(1), top);
        send_request(W'(100), W'(7));
        send_request(W'(7), W'(100));
        send_request(W'(42), W'(42));
        send_request(ones, top + W'(1));
        send_request(W'(1), W'(1));
        wait_drained();
    endtask

    task automatic test_random_requests(input int count);
        repeat (count)
            send_request(random_operand(), random_divisor());
    endtask

    task automatic test_back_to_back(input int count);
        sender_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        test_random_requests(count);
        sender_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
    endtask

    task automatic test_drained_bursts(input int bursts);
        repeat (bursts)
        begin
            test_random_requests($urandom_range(1, 30));
            wait_drained();
            @(negedge clk);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_corner_operands();
        test_random_requests(350);
        test_back_to_back(200);
        test_drained_bursts(10);
        test_random_requests(100);
        wait_drained();
        repeat (2 * W + 20) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
